FILE: hdl/ccs_pkg.sv
// Shared types, constants and the sigmoid table for the causal conv1d SiLU block.
package ccs_pkg;

    // Default sizes
    localparam int CHANNELS_DEF = 1024;
    localparam int TAPS_DEF     = 4;

    // Field widths
    localparam int OPCODE_W  = 2;
    localparam int CHANNEL_W = 10;
    localparam int TAP_FW    = 2;
    localparam int VALUE_W   = 16;
    localparam int SIG_W     = 17;
    localparam int SIG_N     = 256;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_LUT,
        ST_PROD,
        ST_OUT
    } ccs_state_t;

    typedef logic [SIG_N-1:0][15:0] sig_table_t;

    // Shift-subtract unsigned divide, used only while building constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Bin-center sigmoid in Q0.16, e^(-n/32) from repeated Q0.32 products
    function automatic sig_table_t build_sig_table();
        sig_table_t  tbl;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] c;
        logic [63:0] e;
        logic [63:0] pw [SIG_N];
        logic [63:0] ex;
        logic [63:0] d;
        logic [63:0] num;
        int          m;
        int          a;
        term = 64'd1 << 60;
        acc  = term;
        for (int k = 1; k <= 10; k++) begin
            term = udiv64(term, 64'(32 * k));
            if ((k % 2) == 1) acc = acc - term;
            else              acc = acc + term;
        end
        c = (acc + (64'd1 << 27)) >> 28;
        e = 64'd1 << 32;
        pw[0] = e;
        for (int n = 1; n < SIG_N; n++) begin
            e = (e * c + (64'd1 << 31)) >> 32;
            pw[n] = e;
        end
        for (int i = 0; i < SIG_N; i++) begin
            m   = 2 * i + 1 - 256;
            a   = (m < 0) ? -m : m;
            ex  = pw[a];
            d   = (64'd1 << 32) + ex;
            num = (m < 0) ? (ex << 16) : (64'd1 << 48);
            tbl[i] = 16'(udiv64(num + (d >> 1), d));
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

FILE: hdl/causal_conv1d_silu_top.sv
// Per-channel depthwise causal FIR with SiLU, history and weights held in block memories.
// Sample beat: from accept to result register through multiply, sum, lookup, multiply,
//   round (after the memory read at the accept edge), as the single read-modify-write
//   sequence over the history memory.
// Load and clear beats: each written straight into memory.
// s_tready stays low from a sample's accept until its result is loaded into the output.
// Reset: synchronous, active low; then a history clearing sweep over all CHANNELS entries
//   during which s_tready stays low. Tap weights are not cleared.
module causal_conv1d_silu_top
    import ccs_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int TAPS     = TAPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel[9:0], tap[11:10], value[27:12], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_channel[9:0], result[25:10], zero pad
    output logic        m_tuser    // saturated[0]
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W  = $clog2(TAPS);
    localparam int HIST_N = TAPS - 1;
    localparam int SUM_W  = 32 + $clog2(TAPS);
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(-32768);
    localparam logic signed [33:0]      RES_HI = 34'(32767);
    localparam logic signed [33:0]      RES_LO = 34'(-32768);

    // Field unpack
    logic [OPCODE_W-1:0]       in_opcode;
    logic [CHANNEL_W-1:0]      in_channel;
    logic [TAP_FW-1:0]         in_tap;
    logic signed [VALUE_W-1:0] in_value;
    logic                      in_ok;
    logic [ADDR_W-1:0]         in_addr;

    assign in_opcode  = s_tuser;
    assign in_channel = s_tdata[9:0];
    assign in_tap     = s_tdata[11:10];
    assign in_value   = s_tdata[27:12];
    assign in_ok      = 32'(in_channel) < 32'(CHANNELS);
    assign in_addr    = ADDR_W'(in_channel);

    // Memories
    logic [HIST_N-1:0][15:0] hist_mem [CHANNELS];
    logic [TAPS-1:0][15:0]   wt_mem   [CHANNELS];
    logic [HIST_N-1:0][15:0] hist_rd_reg;
    logic [TAPS-1:0][15:0]   wt_rd_reg;

    // Control
    ccs_state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              accept;
    logic              take_sample;
    logic              hist_we;
    logic [ADDR_W-1:0] hist_waddr;
    logic [HIST_N-1:0][15:0] hist_wdata;
    logic              wt_we;
    logic              out_load;

    // Datapath registers
    logic [CHANNEL_W-1:0]      ch_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic signed [31:0]        prod_reg [TAPS];
    logic signed [15:0]        sum_reg;
    logic                      sat_reg;
    logic [SIG_W-1:0]          sig_reg;
    logic signed [33:0]        mul_reg;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [CHANNEL_W-1:0]      m_ch_reg;
    logic signed [15:0]        m_res_reg;
    logic                      m_sat_reg;

    assign accept      = s_tvalid && s_tready;
    assign take_sample = accept && in_ok && (in_opcode == OP_SAMPLE);

    // Next state
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(CHANNELS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:  if (take_sample) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_LUT;
            ST_LUT:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready   = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = addr_reg;
        hist_wdata = '0;
        wt_we      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = clr_cnt_reg;
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                hist_waddr = in_addr;
                hist_we    = accept && in_ok && (in_opcode == OP_CLEAR);
                wt_we      = accept && in_ok && (in_opcode == OP_LOAD)
                             && (32'(in_tap) < 32'(TAPS));
            end
            ST_MUL: begin
                // shift the history and take in the new sample
                hist_we = 1'b1;
                for (int k = 0; k < HIST_N - 1; k++) hist_wdata[k] = hist_rd_reg[k + 1];
                hist_wdata[HIST_N - 1] = val_reg;
            end
            ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Memory ports: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
        if (wt_we)   wt_mem[in_addr][TAP_W'(in_tap)] <= in_value;
        hist_rd_reg <= hist_mem[in_addr];
        wt_rd_reg   <= wt_mem[in_addr];
    end

    // Capture the sample beat
    always_ff @(posedge aclk) begin
        if (take_sample) begin
            ch_reg   <= in_channel;
            addr_reg <= in_addr;
            val_reg  <= in_value;
        end
    end

    // Tap products
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            for (int k = 0; k < HIST_N; k++)
                prod_reg[k] <= $signed(wt_rd_reg[k]) * $signed(hist_rd_reg[k]);
            prod_reg[TAPS - 1] <= $signed(wt_rd_reg[TAPS - 1]) * val_reg;
        end
    end

    // Sum, round to Q8.8 and saturate
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] acc_q;
    always_comb begin
        acc = '0;
        for (int k = 0; k < TAPS; k++) acc = acc + SUM_W'(prod_reg[k]);
        acc_q = (acc + SUM_W'(8192)) >>> 14;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            priority if (acc_q > SUM_HI) begin
                sum_reg <= 16'sh7fff;
                sat_reg <= 1'b1;
            end else if (acc_q < SUM_LO) begin
                sum_reg <= -16'sh8000;
                sat_reg <= 1'b1;
            end else begin
                sum_reg <= 16'(acc_q);
                sat_reg <= 1'b0;
            end
        end
    end

    // Sigmoid lookup
    logic [15:0] sig_off;
    assign sig_off = sum_reg + 16'sd2048;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LUT) begin
            priority if (sum_reg < -16'sd2048) sig_reg <= '0;
            else if (sum_reg >= 16'sd2048)     sig_reg <= SIG_W'(65536);
            else sig_reg <= SIG_W'(SIG_TABLE[sig_off[11:4]]);
        end
    end

    // SiLU product
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PROD) mul_reg <= sum_reg * $signed({1'b0, sig_reg});
    end

    // Round, saturate and hold the result beat
    logic signed [33:0] res_q;
    assign res_q = (mul_reg + 34'sd32768) >>> 16;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;
        if (out_load) m_tvalid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_ch_reg <= ch_reg;
            priority if (res_q > RES_HI) begin
                m_res_reg <= 16'sh7fff;
                m_sat_reg <= 1'b1;
            end else if (res_q < RES_LO) begin
                m_res_reg <= -16'sh8000;
                m_sat_reg <= 1'b1;
            end else begin
                m_res_reg <= 16'(res_q);
                m_sat_reg <= sat_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg, m_ch_reg};
    assign m_tuser  = m_sat_reg;

    // Checks
    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        take_sample |=> state_reg == ST_MUL)
        else $error("sample beat did not start the sequence");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result beat raised outside the output state");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && m_tvalid_reg && !m_tready |=> state_reg == ST_OUT)
        else $error("finished result overwrote a waiting beat");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> !accept)
        else $error("beat accepted while a sample is in flight");

endmodule
